// ===== hw/rtl/srv_pkg.sv =====
`timescale 1ns / 1ps

package srv_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int VEC_W     = 18;   // Q1.16 direction component
    localparam int RI_W      = 16;   // Q4.12 refractive index
    localparam int OUT_W     = 24;   // Q7.16 result component
    localparam int W_W       = 34;   // scaled incident component
    localparam int WN_W      = 37;   // w.n after the shift
    localparam int SAT_W     = 41;   // widest pre-saturation sum

    // Divider: 32 quotient bits, four per stage
    localparam int DIV_NUM_W = 32;
    localparam int DIV_BITS  = 4;
    localparam int DIV_ST    = DIV_NUM_W / DIV_BITS;

    // Square root: 36-bit radicand, 18 root bits, three per stage
    localparam int SQ_RAD_W  = 36;
    localparam int SQ_ROOT_W = SQ_RAD_W / 2;
    localparam int SQ_BITS   = 3;
    localparam int SQ_ST     = SQ_ROOT_W / SQ_BITS;

    typedef logic [2:0][VEC_W-1:0] t_vec3;
    typedef logic [2:0][W_W-1:0]   t_w3;
    typedef logic [2:0][OUT_W-1:0] t_o3;

    // Everything the refraction tail needs while the root is formed
    typedef struct packed {
        t_w3             w;
        t_vec3           nrm;
        logic [WN_W-1:0] wn;
        logic            tir;
        t_o3             res_tir;
    } t_sq_side;

    localparam logic signed [SAT_W-1:0] SAT_HI = 41'sd8388607;
    localparam logic signed [SAT_W-1:0] SAT_LO = -41'sd8388608;

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[OUT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/srv_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, four quotient bits per stage.
module srv_div (
    input  logic                             i_clk,
    input  logic [srv_pkg::DIV_ST-1:0]       i_en,
    input  logic [srv_pkg::DIV_NUM_W-1:0]    i_num,
    input  logic [srv_pkg::RI_W-1:0]         i_den,
    output logic [srv_pkg::DIV_NUM_W-1:0]    o_quo
);

    logic [srv_pkg::RI_W-1:0]      r_rem [srv_pkg::DIV_ST];
    logic [srv_pkg::DIV_NUM_W-1:0] r_num [srv_pkg::DIV_ST];
    logic [srv_pkg::DIV_NUM_W-1:0] r_quo [srv_pkg::DIV_ST];
    logic [srv_pkg::RI_W-1:0]      r_den [srv_pkg::DIV_ST];

    logic [srv_pkg::RI_W-1:0]      s_rem [srv_pkg::DIV_ST];
    logic [srv_pkg::DIV_NUM_W-1:0] s_num [srv_pkg::DIV_ST];
    logic [srv_pkg::DIV_NUM_W-1:0] s_quo [srv_pkg::DIV_ST];
    logic [srv_pkg::RI_W-1:0]      s_den [srv_pkg::DIV_ST];

    logic [srv_pkg::RI_W-1:0]      n_rem [srv_pkg::DIV_ST];
    logic [srv_pkg::DIV_NUM_W-1:0] n_num [srv_pkg::DIV_ST];
    logic [srv_pkg::DIV_NUM_W-1:0] n_quo [srv_pkg::DIV_ST];

    genvar j;
    generate
        for (j = 0; j < srv_pkg::DIV_ST; j++) begin : g_st
            if (j == 0) begin : g_first
                assign s_rem[j] = '0;
                assign s_num[j] = i_num;
                assign s_quo[j] = '0;
                assign s_den[j] = i_den;
            end else begin : g_next
                assign s_rem[j] = r_rem[j-1];
                assign s_num[j] = r_num[j-1];
                assign s_quo[j] = r_quo[j-1];
                assign s_den[j] = r_den[j-1];
            end

            always_comb begin : p_step
                logic [srv_pkg::RI_W:0]        t;
                logic [srv_pkg::RI_W-1:0]      rem;
                logic [srv_pkg::DIV_NUM_W-1:0] num;
                logic [srv_pkg::DIV_NUM_W-1:0] quo;
                rem = s_rem[j];
                num = s_num[j];
                quo = s_quo[j];
                t   = '0;
                for (int b = 0; b < srv_pkg::DIV_BITS; b++) begin
                    t   = {rem, num[srv_pkg::DIV_NUM_W-1]};
                    num = {num[srv_pkg::DIV_NUM_W-2:0], 1'b0};
                    if (t >= {1'b0, s_den[j]}) begin
                        t   = t - {1'b0, s_den[j]};
                        quo = {quo[srv_pkg::DIV_NUM_W-2:0], 1'b1};
                    end else begin
                        quo = {quo[srv_pkg::DIV_NUM_W-2:0], 1'b0};
                    end
                    rem = t[srv_pkg::RI_W-1:0];
                end
                n_rem[j] = rem;
                n_num[j] = num;
                n_quo[j] = quo;
            end

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= n_rem[j];
                    r_num[j] <= n_num[j];
                    r_quo[j] <= n_quo[j];
                    r_den[j] <= s_den[j];
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[srv_pkg::DIV_ST-1];

endmodule

// ===== hw/rtl/srv_sqrt.sv =====
`timescale 1ns / 1ps

// Pipelined digit-by-digit integer square root (floor), three root bits per stage.
module srv_sqrt (
    input  logic                            i_clk,
    input  logic [srv_pkg::SQ_ST-1:0]       i_en,
    input  logic [srv_pkg::SQ_RAD_W-1:0]    i_rad,
    output logic [srv_pkg::SQ_ROOT_W-1:0]   o_root
);

    localparam int REM_W = srv_pkg::SQ_ROOT_W + 2;

    logic [REM_W-1:0]              r_rem  [srv_pkg::SQ_ST];
    logic [srv_pkg::SQ_RAD_W-1:0]  r_rad  [srv_pkg::SQ_ST];
    logic [srv_pkg::SQ_ROOT_W-1:0] r_root [srv_pkg::SQ_ST];

    logic [REM_W-1:0]              s_rem  [srv_pkg::SQ_ST];
    logic [srv_pkg::SQ_RAD_W-1:0]  s_rad  [srv_pkg::SQ_ST];
    logic [srv_pkg::SQ_ROOT_W-1:0] s_root [srv_pkg::SQ_ST];

    logic [REM_W-1:0]              n_rem  [srv_pkg::SQ_ST];
    logic [srv_pkg::SQ_RAD_W-1:0]  n_rad  [srv_pkg::SQ_ST];
    logic [srv_pkg::SQ_ROOT_W-1:0] n_root [srv_pkg::SQ_ST];

    genvar j;
    generate
        for (j = 0; j < srv_pkg::SQ_ST; j++) begin : g_st
            if (j == 0) begin : g_first
                assign s_rem[j]  = '0;
                assign s_rad[j]  = i_rad;
                assign s_root[j] = '0;
            end else begin : g_next
                assign s_rem[j]  = r_rem[j-1];
                assign s_rad[j]  = r_rad[j-1];
                assign s_root[j] = r_root[j-1];
            end

            always_comb begin : p_step
                logic [REM_W+1:0]              t;
                logic [REM_W-1:0]              trial;
                logic [REM_W-1:0]              rem;
                logic [srv_pkg::SQ_RAD_W-1:0]  rad;
                logic [srv_pkg::SQ_ROOT_W-1:0] root;
                rem   = s_rem[j];
                rad   = s_rad[j];
                root  = s_root[j];
                t     = '0;
                trial = '0;
                for (int b = 0; b < srv_pkg::SQ_BITS; b++) begin
                    t     = {rem, rad[srv_pkg::SQ_RAD_W-1 -: 2]};
                    rad   = {rad[srv_pkg::SQ_RAD_W-3:0], 2'b00};
                    trial = {root, 2'b01};
                    if (t >= {2'b00, trial}) begin
                        t    = t - {2'b00, trial};
                        root = {root[srv_pkg::SQ_ROOT_W-2:0], 1'b1};
                    end else begin
                        root = {root[srv_pkg::SQ_ROOT_W-2:0], 1'b0};
                    end
                    rem = t[REM_W-1:0];
                end
                n_rem[j]  = rem;
                n_rad[j]  = rad;
                n_root[j] = root;
            end

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j]  <= n_rem[j];
                    r_rad[j]  <= n_rad[j];
                    r_root[j] <= n_root[j];
                end
            end
        end
    endgenerate

    assign o_root = r_root[srv_pkg::SQ_ST-1];

endmodule

// ===== hw/rtl/snell_refraction_vector.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// s        in         i_s_tvalid/o_s_tready   i_s_tdata: incident, normal, indices
// m        out        o_m_tvalid/i_m_tready   o_m_tdata: out x/y/z, o_m_tuser: refracted
//
// One item is accepted per clock while o_s_tready is high.
// The pipeline holds the 8-stage divider for the index ratio, the 6-stage
// square root and the multiplier stages between them.
// Reset (synchronous, active low) clears only the stage valid bits.
// Every stage holds its item while the stage after it is full and stalled, so
// empty stages keep filling while a finished item waits at the output.
module snell_refraction_vector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // [17:0] incident_x, [35:18] incident_y, [53:36] incident_z,
    // [71:54] normal_x, [89:72] normal_y, [107:90] normal_z,
    // [123:108] ri_from, [139:124] ri_to, [143:140] zero
    input  logic [143:0]  i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [23:0] out_x, [47:24] out_y, [71:48] out_z
    output logic [71:0]   o_m_tdata,
    // [0] refracted
    output logic          o_m_tuser
);

    // Stage map of the pipeline.
    localparam int S_IN   = 0;
    localparam int S_DIV0 = 1;
    localparam int S_W    = S_DIV0 + srv_pkg::DIV_ST;
    localparam int S_P    = S_W + 1;
    localparam int S_U    = S_P + 1;
    localparam int S_SQ   = S_U + 1;
    localparam int S_UU   = S_SQ + 1;
    localparam int S_RT0  = S_UU + 1;
    localparam int S_BETA = S_RT0 + srv_pkg::SQ_ST;
    localparam int S_PB   = S_BETA + 1;
    localparam int S_OUT  = S_PB + 1;
    localparam int NST    = S_OUT + 1;

    localparam int IDX_W = srv_pkg::VEC_W;

    // Stage valid bits and the enable chain. A stage loads when it is empty
    // or when the stage after it loads as well.
    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[S_IN]) begin
                r_v[S_IN] <= i_s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_s_tready = en[S_IN];

    // Input stage. A zero index makes the ratio exactly one: 1.0 / 1.
    srv_pkg::t_vec3                  r_inc0, r_nrm0;
    logic [srv_pkg::DIV_NUM_W-1:0]   r_num0;
    logic [srv_pkg::RI_W-1:0]        r_den0;

    always_ff @(posedge i_clk) begin
        if (en[S_IN]) begin
            r_inc0 <= i_s_tdata[53:0];
            r_nrm0 <= i_s_tdata[107:54];
            if (i_s_tdata[123:108] == '0 || i_s_tdata[139:124] == '0) begin
                r_num0 <= 32'h0001_0000;
                r_den0 <= 16'd1;
            end else begin
                r_num0 <= {i_s_tdata[123:108], 16'h0000};
                r_den0 <= i_s_tdata[139:124];
            end
        end
    end

    // Ratio divider, with the ray travelling beside it.
    logic [srv_pkg::DIV_NUM_W-1:0] quo;

    srv_div u_div (
        .i_clk (i_clk),
        .i_en  (en[S_DIV0 +: srv_pkg::DIV_ST]),
        .i_num (r_num0),
        .i_den (r_den0),
        .o_quo (quo)
    );

    srv_pkg::t_vec3 r_inc_d [srv_pkg::DIV_ST];
    srv_pkg::t_vec3 r_nrm_d [srv_pkg::DIV_ST];

    genvar g;
    generate
        for (g = 0; g < srv_pkg::DIV_ST; g++) begin : g_dside
            if (g == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (en[S_DIV0 + g]) begin
                        r_inc_d[g] <= r_inc0;
                        r_nrm_d[g] <= r_nrm0;
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (en[S_DIV0 + g]) begin
                        r_inc_d[g] <= r_inc_d[g-1];
                        r_nrm_d[g] <= r_nrm_d[g-1];
                    end
                end
            end
        end
    endgenerate

    // w = ratio * incident, floored.
    srv_pkg::t_w3   r_w9;
    srv_pkg::t_vec3 r_inc9, r_nrm9;
    logic signed [49:0] prod_w [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_w[k] = $signed({1'b0, quo}) * $signed(r_inc_d[srv_pkg::DIV_ST-1][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_W]) begin
            for (int k = 0; k < 3; k++) begin
                r_w9[k] <= prod_w[k][49:16];
            end
            r_inc9 <= r_inc_d[srv_pkg::DIV_ST-1];
            r_nrm9 <= r_nrm_d[srv_pkg::DIV_ST-1];
        end
    end

    // Products for the cross product, for w.n and for the incident dot product.
    logic signed [50:0] r_pc [6];
    logic signed [50:0] r_pw [3];
    logic signed [37:0] r_dot;
    srv_pkg::t_w3       r_w10;
    srv_pkg::t_vec3     r_inc10, r_nrm10;
    logic signed [50:0] n_pc [6];
    logic signed [50:0] n_pw [3];
    logic signed [37:0] n_dot;

    always_comb begin
        n_pc[0] = $signed(r_w9[1]) * $signed(r_nrm9[2]);
        n_pc[1] = $signed(r_w9[2]) * $signed(r_nrm9[1]);
        n_pc[2] = $signed(r_w9[2]) * $signed(r_nrm9[0]);
        n_pc[3] = $signed(r_w9[0]) * $signed(r_nrm9[2]);
        n_pc[4] = $signed(r_w9[0]) * $signed(r_nrm9[1]);
        n_pc[5] = $signed(r_w9[1]) * $signed(r_nrm9[0]);
        for (int k = 0; k < 3; k++) begin
            n_pw[k] = $signed(r_w9[k]) * $signed(r_nrm9[k]);
        end
        n_dot = $signed(r_inc9[0]) * $signed(r_nrm9[0])
              + $signed(r_inc9[1]) * $signed(r_nrm9[1])
              + $signed(r_inc9[2]) * $signed(r_nrm9[2]);
    end

    always_ff @(posedge i_clk) begin
        if (en[S_P]) begin
            r_pc    <= n_pc;
            r_pw    <= n_pw;
            r_dot   <= n_dot;
            r_w10   <= r_w9;
            r_inc10 <= r_inc9;
            r_nrm10 <= r_nrm9;
        end
    end

    // u = w x n, w.n, and t = floor(-(I.N)).
    logic signed [35:0] r_u [3];
    logic signed [36:0] r_wn;
    logic signed [22:0] r_t;
    srv_pkg::t_w3       r_w11;
    srv_pkg::t_vec3     r_inc11, r_nrm11;
    logic signed [51:0] diff [3];
    logic signed [52:0] wn_sum;
    logic signed [38:0] neg_dot;

    always_comb begin
        diff[0] = r_pc[0] - r_pc[1];
        diff[1] = r_pc[2] - r_pc[3];
        diff[2] = r_pc[4] - r_pc[5];
        wn_sum  = r_pw[0] + r_pw[1] + r_pw[2];
        neg_dot = -r_dot;
    end

    always_ff @(posedge i_clk) begin
        if (en[S_U]) begin
            for (int k = 0; k < 3; k++) begin
                r_u[k] <= diff[k][51:16];
            end
            r_wn    <= wn_sum[52:16];
            r_t     <= neg_dot[38:16];
            r_w11   <= r_w10;
            r_inc11 <= r_inc10;
            r_nrm11 <= r_nrm10;
        end
    end

    // Squares of the bounded u components, and the reflection products t * n.
    logic [32:0]        r_sq [3];
    logic               r_big;
    logic signed [40:0] r_tp [3];
    logic signed [36:0] r_wn12;
    srv_pkg::t_w3       r_w12;
    srv_pkg::t_vec3     r_inc12, r_nrm12;
    logic signed [35:0] sq_full [3];
    logic signed [40:0] tp_full [3];
    logic [2:0]         big_k;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            big_k[k]   = (r_u[k] > 36'sd65536) || (r_u[k] < -36'sd65536);
            sq_full[k] = $signed(r_u[k][IDX_W-1:0]) * $signed(r_u[k][IDX_W-1:0]);
            tp_full[k] = r_t * $signed(r_nrm11[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_SQ]) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= sq_full[k][32:0];
            end
            r_big   <= |big_k;
            r_tp    <= tp_full;
            r_wn12  <= r_wn;
            r_w12   <= r_w11;
            r_inc12 <= r_inc11;
            r_nrm12 <= r_nrm11;
        end
    end

    // u.u against one, the root radicand, and the finished reflection result.
    localparam logic [34:0] ONE_SQ = 35'h1_0000_0000;

    logic               r_tir13;
    logic [32:0]        r_rad;
    srv_pkg::t_sq_side  r_side13;
    logic [34:0]        uu;
    logic               tir;
    logic [34:0]        rad_full;
    logic signed [41:0] tp2 [3];
    logic signed [26:0] rsum [3];
    srv_pkg::t_o3       res_tir;

    always_comb begin
        uu       = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
        tir      = r_big || (uu > ONE_SQ);
        rad_full = ONE_SQ - uu;
        for (int k = 0; k < 3; k++) begin
            tp2[k]     = {r_tp[k], 1'b0};
            rsum[k]    = $signed(tp2[k][41:16]) + $signed(r_inc12[k]);
            res_tir[k] = srv_pkg::sat_out(41'(rsum[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_UU]) begin
            r_tir13          <= tir;
            r_rad            <= tir ? 33'd0 : rad_full[32:0];
            r_side13.w       <= r_w12;
            r_side13.nrm     <= r_nrm12;
            r_side13.wn      <= r_wn12;
            r_side13.tir     <= tir;
            r_side13.res_tir <= res_tir;
        end
    end

    // Square root of 1 - u.u, with the rest of the item beside it.
    logic [srv_pkg::SQ_ROOT_W-1:0] root;

    srv_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en[S_RT0 +: srv_pkg::SQ_ST]),
        .i_rad  ({3'b000, r_rad}),
        .o_root (root)
    );

    srv_pkg::t_sq_side r_side_s [srv_pkg::SQ_ST];

    generate
        for (g = 0; g < srv_pkg::SQ_ST; g++) begin : g_sside
            if (g == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (en[S_RT0 + g]) begin
                        r_side_s[g] <= r_side13;
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (en[S_RT0 + g]) begin
                        r_side_s[g] <= r_side_s[g-1];
                    end
                end
            end
        end
    endgenerate

    // beta = -root - w.n
    logic signed [37:0] r_beta;
    srv_pkg::t_sq_side  r_side20;
    logic signed [37:0] beta;

    always_comb begin
        beta = -$signed({20'd0, root}) - $signed(r_side_s[srv_pkg::SQ_ST-1].wn);
    end

    always_ff @(posedge i_clk) begin
        if (en[S_BETA]) begin
            r_beta   <= beta;
            r_side20 <= r_side_s[srv_pkg::SQ_ST-1];
        end
    end

    // n * beta
    logic signed [55:0] r_pb [3];
    srv_pkg::t_w3       r_w21;
    logic               r_tir21;
    srv_pkg::t_o3       r_res_tir21;
    logic signed [55:0] pb [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pb[k] = $signed(r_side20.nrm[k]) * r_beta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_PB]) begin
            r_pb        <= pb;
            r_w21       <= r_side20.w;
            r_tir21     <= r_side20.tir;
            r_res_tir21 <= r_side20.res_tir;
        end
    end

    // Output register: refraction sum, saturation and the choice of result.
    srv_pkg::t_o3       r_out;
    logic               r_refr;
    logic signed [40:0] rr [3];
    srv_pkg::t_o3       out_c;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rr[k]    = $signed(r_w21[k]) + $signed(r_pb[k][55:16]);
            out_c[k] = r_tir21 ? r_res_tir21[k] : srv_pkg::sat_out(rr[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            r_out  <= out_c;
            r_refr <= !r_tir21;
        end
    end

    assign o_m_tvalid = r_v[S_OUT];
    assign o_m_tdata  = r_out;
    assign o_m_tuser  = r_refr;

    // The input side only stalls when every stage holds an item and the
    // output is not being taken.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_v) && !i_m_tready)
        else $error("input stalled with an empty stage in the pipeline");

    // A totally reflected ray must feed a zero radicand to the root.
    a_tir_zero_rad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[S_UU] && r_tir13 |-> r_rad == 33'd0)
        else $error("radicand not cleared for a reflected ray");

    // The root of a value no larger than one cannot exceed one.
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[S_BETA - 1] |-> root <= 18'd65536)
        else $error("square root above one");

endmodule
